// File: rtl/fac_pkg.sv
// ---------------------------------------------------------------------------
// fac_pkg: shared types and constants for the four-level alarm check
// Value width, register map, status codes and payload structs.
// ---------------------------------------------------------------------------
package fac_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int HYST_WIDTH  = 31;
  localparam int SEV_WIDTH   = 2;
  localparam int CODE_WIDTH  = 3;
  localparam int NUM_LEVELS  = 4;

  // limit +/- hysteresis never wraps at this width
  localparam int SUM_WIDTH =
    ((VALUE_WIDTH > HYST_WIDTH + 1) ? VALUE_WIDTH : HYST_WIDTH + 1) + 1;

  // configuration port geometry
  localparam int DATA_WIDTH = (VALUE_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_LSB   = (VALUE_WIDTH > 32) ? 3 : 2;
  localparam int INDEX_WIDTH = 3;
  localparam int ADDR_WIDTH = ADDR_LSB + INDEX_WIDTH;

  localparam logic [INDEX_WIDTH-1:0] REG_HIHI_LIMIT = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_LOLO_LIMIT = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_HIGH_LIMIT = 3'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_LOW_LIMIT  = 3'd3;
  localparam logic [INDEX_WIDTH-1:0] REG_HYSTERESIS = 3'd4;
  localparam logic [INDEX_WIDTH-1:0] REG_LEVEL_SEV  = 3'd5;

  localparam logic [CODE_WIDTH-1:0] STATUS_NONE = 3'd0;
  localparam logic [CODE_WIDTH-1:0] STATUS_HIHI = 3'd1;
  localparam logic [CODE_WIDTH-1:0] STATUS_LOLO = 3'd2;
  localparam logic [CODE_WIDTH-1:0] STATUS_HIGH = 3'd3;
  localparam logic [CODE_WIDTH-1:0] STATUS_LOW  = 3'd4;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample;
    logic [SEV_WIDTH-1:0]          prior_severity;
  } fac_in_t;

  typedef struct packed {
    logic [SEV_WIDTH-1:0]  new_severity;
    logic [CODE_WIDTH-1:0] status_code;
  } fac_out_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] hihi_limit;
    logic signed [VALUE_WIDTH-1:0] lolo_limit;
    logic signed [VALUE_WIDTH-1:0] high_limit;
    logic signed [VALUE_WIDTH-1:0] low_limit;
    logic [HYST_WIDTH-1:0]         hysteresis;
    logic [2*NUM_LEVELS-1:0]       level_severities;
  } fac_cfg_t;

  // outcome of one item's level check
  typedef struct packed {
    logic                          matched;
    logic                          raise;
    logic [SEV_WIDTH-1:0]          severity;
    logic [CODE_WIDTH-1:0]         code;
    logic signed [VALUE_WIDTH-1:0] level;
  } fac_decision_t;

endpackage

// File: rtl/fac_cfg_regs.sv
// ---------------------------------------------------------------------------
// fac_cfg_regs: configuration register file
// APB-style write and read access to the limits, hysteresis and severities.
// ---------------------------------------------------------------------------
module fac_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fac_pkg::ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [fac_pkg::DATA_WIDTH-1:0]  cfg_pwdata,
  output logic [fac_pkg::DATA_WIDTH-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output fac_pkg::fac_cfg_t               cfg
);
  import fac_pkg::*;

  fac_cfg_t               cfg_r;
  fac_cfg_t               cfg_nxt;
  logic [INDEX_WIDTH-1:0] index;
  logic                   wr_en;

  assign index      = cfg_paddr[ADDR_WIDTH-1:ADDR_LSB];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (index)
        REG_HIHI_LIMIT: cfg_nxt.hihi_limit = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_LOLO_LIMIT: cfg_nxt.lolo_limit = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_HIGH_LIMIT: cfg_nxt.high_limit = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_LOW_LIMIT:  cfg_nxt.low_limit  = cfg_pwdata[VALUE_WIDTH-1:0];
        REG_HYSTERESIS: cfg_nxt.hysteresis = cfg_pwdata[HYST_WIDTH-1:0];
        REG_LEVEL_SEV:  cfg_nxt.level_severities = cfg_pwdata[2*NUM_LEVELS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (index)
      REG_HIHI_LIMIT: cfg_prdata = DATA_WIDTH'($unsigned(cfg_r.hihi_limit));
      REG_LOLO_LIMIT: cfg_prdata = DATA_WIDTH'($unsigned(cfg_r.lolo_limit));
      REG_HIGH_LIMIT: cfg_prdata = DATA_WIDTH'($unsigned(cfg_r.high_limit));
      REG_LOW_LIMIT:  cfg_prdata = DATA_WIDTH'($unsigned(cfg_r.low_limit));
      REG_HYSTERESIS: cfg_prdata = DATA_WIDTH'(cfg_r.hysteresis);
      REG_LEVEL_SEV:  cfg_prdata = DATA_WIDTH'(cfg_r.level_severities);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// File: rtl/fac_level_check.sv
// ---------------------------------------------------------------------------
// fac_level_check: priority limit check for one item
// Compares the sample against hihi, lolo, high and low with hysteresis.
// ---------------------------------------------------------------------------
module fac_level_check (
  input  fac_pkg::fac_in_t                        item,
  input  fac_pkg::fac_cfg_t                       cfg,
  input  logic signed [fac_pkg::VALUE_WIDTH-1:0]  last_level,
  output fac_pkg::fac_decision_t                  decision
);
  import fac_pkg::*;

  localparam logic [NUM_LEVELS-1:0] UPWARD = 4'b0101;

  logic signed [VALUE_WIDTH-1:0] lims [NUM_LEVELS];
  logic signed [SUM_WIDTH-1:0]   lim_ext [NUM_LEVELS];
  logic signed [SUM_WIDTH-1:0]   band [NUM_LEVELS];
  logic signed [SUM_WIDTH-1:0]   v_ext;
  logic signed [SUM_WIDTH-1:0]   hy_ext;
  logic [SEV_WIDTH-1:0]          lsev [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]         hit;
  logic                          found;

  assign lims[0] = cfg.hihi_limit;
  assign lims[1] = cfg.lolo_limit;
  assign lims[2] = cfg.high_limit;
  assign lims[3] = cfg.low_limit;

  assign v_ext  = SUM_WIDTH'(item.sample);
  assign hy_ext = SUM_WIDTH'(cfg.hysteresis);

  always_comb begin
    for (int k = 0; k < NUM_LEVELS; k++) begin
      lsev[k]    = cfg.level_severities[2*k +: SEV_WIDTH];
      lim_ext[k] = SUM_WIDTH'(lims[k]);
      if (UPWARD[k]) begin
        band[k] = lim_ext[k] - hy_ext;
        hit[k]  = (lsev[k] != '0) &&
                  ((v_ext >= lim_ext[k]) ||
                   ((last_level == lims[k]) && (v_ext >= band[k])));
      end else begin
        band[k] = lim_ext[k] + hy_ext;
        hit[k]  = (lsev[k] != '0) &&
                  ((v_ext <= lim_ext[k]) ||
                   ((last_level == lims[k]) && (v_ext <= band[k])));
      end
    end
  end

  // first matching level wins; lower priorities are ignored
  always_comb begin
    found             = 1'b0;
    decision.matched  = 1'b0;
    decision.raise    = 1'b0;
    decision.severity = item.prior_severity;
    decision.code     = STATUS_NONE;
    decision.level    = item.sample;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (!found && hit[k]) begin
        found            = 1'b1;
        decision.matched = 1'b1;
        decision.level   = lims[k];
        if (lsev[k] > item.prior_severity) begin
          decision.raise    = 1'b1;
          decision.severity = lsev[k];
          decision.code     = CODE_WIDTH'(k + 1);
        end
      end
    end
  end

endmodule

// File: rtl/four_level_alarm_check_top.sv
// ---------------------------------------------------------------------------
// four_level_alarm_check_top: four-level analog alarm check with hysteresis
// Input register, combinational level check, result register.
// ---------------------------------------------------------------------------
// One item per clock while the result side keeps up: a sample is registered
// on acceptance, checked against the four limits by combinational logic and
// lands in the result register. The last alarm level register is updated
// when an item leaves the check with no match or with a raise, so the
// following item sees it at once. Configuration should be written through
// the APB port only while the block holds no items; the block itself does
// not enforce this. Valid flags, configuration and last level reset to zero.
module four_level_alarm_check_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fac_pkg::fac_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fac_pkg::fac_out_t               out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fac_pkg::ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [fac_pkg::DATA_WIDTH-1:0]  cfg_pwdata,
  output logic [fac_pkg::DATA_WIDTH-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import fac_pkg::*;

  fac_cfg_t                      cfg;
  fac_decision_t                 decision;

  fac_in_t                       in_r;
  logic                          in_valid_r;
  logic                          in_valid_nxt;
  fac_out_t                      out_r;
  fac_out_t                      out_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] last_level_r;
  logic signed [VALUE_WIDTH-1:0] last_level_nxt;

  logic out_free;
  logic advance;
  logic in_take;

  fac_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  fac_level_check u_level_check (
    .item      (in_r),
    .cfg       (cfg),
    .last_level(last_level_r),
    .decision  (decision)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt   = in_valid_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    last_level_nxt = last_level_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt        = 1'b1;
      out_nxt.new_severity = decision.severity;
      out_nxt.status_code  = decision.code;
      in_valid_nxt         = 1'b0;
      // no match records the sample, a raise records the limit
      if (!decision.matched || decision.raise) begin
        last_level_nxt = decision.level;
      end
    end
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_level_r <= '0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      last_level_r <= last_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/four_level_alarm_check_top_tb.sv
// ---------------------------------------------------------------------------
// four_level_alarm_check_top_tb: self-checking bench for the alarm check
// Drives samples through the valid/stall input channel and programs limits
// over APB. A scoreboard predicts severity and status per item, tracking the
// last alarm level, and compares each result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

class alarm_scoreboard;
  // limits in priority order: hihi, lolo, high, low
  longint                  lim [4];
  logic [30:0]             hyst;
  logic [7:0]              sev_map;
  longint                  last_level;
  fac_pkg::fac_out_t       expected_q [$];
  int                      errors;
  int                      n_items;
  int                      n_results;
  int                      n_raised;
  int                      n_band;
  int                      n_held;
  int                      n_clear;

  function new();
    for (int k = 0; k < 4; k++) lim[k] = 0;
    hyst       = '0;
    sev_map    = '0;
    last_level = 0;
    errors     = 0;
    n_items    = 0;
    n_results  = 0;
    n_raised   = 0;
    n_band     = 0;
    n_held     = 0;
    n_clear    = 0;
  endfunction

  function void write_reg(logic [fac_pkg::INDEX_WIDTH-1:0] idx,
                          logic [fac_pkg::DATA_WIDTH-1:0] data);
    case (idx)
      fac_pkg::REG_HIHI_LIMIT: lim[0] = $signed(data[fac_pkg::VALUE_WIDTH-1:0]);
      fac_pkg::REG_LOLO_LIMIT: lim[1] = $signed(data[fac_pkg::VALUE_WIDTH-1:0]);
      fac_pkg::REG_HIGH_LIMIT: lim[2] = $signed(data[fac_pkg::VALUE_WIDTH-1:0]);
      fac_pkg::REG_LOW_LIMIT:  lim[3] = $signed(data[fac_pkg::VALUE_WIDTH-1:0]);
      fac_pkg::REG_HYSTERESIS: hyst = data[30:0];
      fac_pkg::REG_LEVEL_SEV:  sev_map = data[7:0];
      default: ;
    endcase
  endfunction

  // work out severity and status for one accepted sample
  function void note_item(fac_pkg::fac_in_t item);
    longint            v;
    longint            hy;
    logic [1:0]        lsev;
    logic [1:0]        prior;
    bit                upward;
    bit                by_limit;
    bit                by_band;
    bit                matched;
    fac_pkg::fac_out_t res;
    v       = $signed(item.sample);
    prior   = item.prior_severity;
    hy      = longint'(hyst);
    matched = 1'b0;
    res.new_severity = prior;
    res.status_code  = fac_pkg::STATUS_NONE;
    for (int k = 0; k < 4 && !matched; k++) begin
      lsev   = sev_map[2*k +: 2];
      upward = (k % 2 == 0);
      if (upward) begin
        by_limit = v >= lim[k];
        by_band  = last_level == lim[k] && v >= lim[k] - hy;
      end else begin
        by_limit = v <= lim[k];
        by_band  = last_level == lim[k] && v <= lim[k] + hy;
      end
      if (lsev != 0 && (by_limit || by_band)) begin
        matched = 1'b1;
        if (!by_limit) n_band++;
        if (lsev > prior) begin
          res.new_severity = lsev;
          case (k)
            0: res.status_code = fac_pkg::STATUS_HIHI;
            1: res.status_code = fac_pkg::STATUS_LOLO;
            2: res.status_code = fac_pkg::STATUS_HIGH;
            default: res.status_code = fac_pkg::STATUS_LOW;
          endcase
          last_level = lim[k];
          n_raised++;
        end else begin
          n_held++;
        end
      end
    end
    if (!matched) begin
      last_level = v;
      n_clear++;
    end
    n_items++;
    expected_q.push_back(res);
  endfunction

  function void check_result(fac_pkg::fac_out_t got);
    fac_pkg::fac_out_t exp_res;
    n_results++;
    if (expected_q.size() == 0) begin
      $display("%0t: result with no item outstanding: severity %0d status %0d",
               $time, got.new_severity, got.status_code);
      errors++;
    end else begin
      exp_res = expected_q.pop_front();
      if (got.new_severity !== exp_res.new_severity) begin
        $display("%0t: new_severity expected %0d actual %0d",
                 $time, exp_res.new_severity, got.new_severity);
        errors++;
      end
      if (got.status_code !== exp_res.status_code) begin
        $display("%0t: status_code expected %0d actual %0d",
                 $time, exp_res.status_code, got.status_code);
        errors++;
      end
    end
  endfunction
endclass

module four_level_alarm_check_top_tb;
  import fac_pkg::*;

  localparam logic [INDEX_WIDTH-1:0] REG_SPARE = 3'd6;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  typedef enum {
    CFG_ORDERED, CFG_WIDE_BAND, CFG_NO_BAND, CFG_SCATTER, CFG_EXTREME, CFG_DISABLED
  } cfg_style_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  fac_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  fac_out_t              out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_WIDTH-1:0] cfg_paddr;
  logic [DATA_WIDTH-1:0] cfg_pwdata;
  logic [DATA_WIDTH-1:0] cfg_prdata;
  logic                  cfg_pready;

  alarm_scoreboard sb;

  // receiver state
  logic        hold_req;
  bit          hold_seen   = 1'b0;
  int          hold_left   = 0;
  int          pat_age     = 0;
  int          stall_mode  = 0;
  logic [15:0] stall_pat   = '0;

  // sender state
  longint      prev_sample = 0;
  int          burst_left  = 0;
  bit          idle_on     = 1'b0;
  int          n_configs   = 0;

  four_level_alarm_check_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 400;
      end
      if (pat_age == 0) begin
        pat_age    = $urandom_range(32, 160);
        stall_mode = $urandom_range(0, 3);
        stall_pat  = 16'($urandom());
      end
      pat_age--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= stall_pat[0];
          2: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= stall_pat[0] & stall_pat[1];
        endcase
      end
    end
  end

  task automatic cfg_write(input logic [INDEX_WIDTH-1:0] idx,
                           input logic [DATA_WIDTH-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, {ADDR_LSB{1'b0}}};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // hold the item until taken
  task automatic send_item(input logic [31:0] s, input logic [1:0] p, input int gap);
    fac_in_t it;
    it.sample         = s;
    it.prior_severity = p;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_limits(input logic [31:0] hh, input logic [31:0] ll,
                            input logic [31:0] hi, input logic [31:0] lo,
                            input logic [30:0] hy, input logic [7:0] sev);
    logic [31:0] w;
    cfg_write(REG_HIHI_LIMIT, hh);
    cfg_write(REG_LOLO_LIMIT, ll);
    cfg_write(REG_HIGH_LIMIT, hi);
    cfg_write(REG_LOW_LIMIT, lo);
    // junk in the bits above each field
    w = $urandom();
    w[30:0] = hy;
    cfg_write(REG_HYSTERESIS, w);
    w = $urandom();
    w[7:0] = sev;
    cfg_write(REG_LEVEL_SEV, w);
    cfg_write(REG_SPARE, $urandom());
    n_configs++;
  endtask

  task automatic cfg_random(input cfg_style_e style);
    int          c;
    int          d1;
    int          d2;
    logic [30:0] hy;
    logic [7:0]  sev;
    c   = $urandom_range(0, 20000) - 10000;
    d1  = $urandom_range(1, 2000);
    d2  = $urandom_range(1, 2000);
    hy  = 31'($urandom_range(0, d1));
    sev = 8'($urandom());
    case (style)
      CFG_WIDE_BAND: cfg_limits(c + d1 + d2, c - d1 - d2, c + d1, c - d1,
                                31'($urandom_range(d1, 3 * (d1 + d2))), sev);
      CFG_NO_BAND:   cfg_limits(c + d1 + d2, c - d1 - d2, c + d1, c - d1, '0, sev);
      CFG_SCATTER:   cfg_limits($urandom(), $urandom(), $urandom(), $urandom(),
                                31'($urandom()), sev);
      CFG_EXTREME:   cfg_limits($urandom_range(0, 1) ? VAL_MAX : VAL_MIN,
                                $urandom_range(0, 1) ? VAL_MAX : VAL_MIN,
                                $urandom_range(0, 1) ? VAL_MAX : VAL_MIN,
                                $urandom_range(0, 1) ? VAL_MAX : VAL_MIN,
                                $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, 8'hFF);
      CFG_DISABLED:  cfg_limits(c + d1 + d2, c - d1 - d2, c + d1, c - d1, hy, 8'h00);
      default:       cfg_limits(c + d1 + d2, c - d1 - d2, c + d1, c - d1, hy, sev);
    endcase
  endtask

  // mostly samples near a limit or inside its band, some walks and noise
  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    int unsigned band;
    longint      base;
    longint      off;
    longint      v;
    sel  = $urandom_range(0, 99);
    base = sb.lim[2'($urandom_range(0, 3))];
    band = sb.hyst + 4;
    off  = longint'($urandom_range(0, band));
    if ($urandom_range(0, 1)) off = -off;
    if (sel < 45) v = base + off;
    else if (sel < 60) v = base + longint'($urandom_range(0, 2)) - 1;
    else if (sel < 80) v = prev_sample + off;
    else if (sel < 95) v = longint'($signed($urandom()));
    else v = sel[0] ? $signed(VAL_MAX) : $signed(VAL_MIN);
    prev_sample = longint'($signed(v[31:0]));
    return v[31:0];
  endfunction

  task automatic run_random(input cfg_style_e style, input int n, input bit busy);
    int         gap;
    logic [1:0] prior;
    cfg_random(style);
    idle_on = busy ? 1'b0 : ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      gap = 0;
      if (idle_on) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = $urandom_range(1, 6);
        end
        burst_left--;
      end
      prior = ($urandom_range(0, 9) < 6) ? 2'd0 : 2'($urandom_range(0, 3));
      send_item(pick_sample(), prior, gap);
    end
    drain();
  endtask

  initial begin
    sb          = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    hold_req    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every level disabled
    send_item(VAL_MAX, 2'd0, 0);
    send_item(VAL_MIN, 2'd3, 0);
    drain();

    // nested limits with a band of 50
    cfg_limits(32'd1000, -32'sd1000, 32'd500, -32'sd500, 31'd50, 8'h5A);
    send_item(32'd1000, 2'd0, 0);       // hihi raise
    send_item(32'd960, 2'd0, 0);        // hihi held by band
    send_item(32'd940, 2'd0, 0);        // band left, falls to high
    send_item(32'd460, 2'd0, 1);        // high held by band
    send_item(32'd100, 2'd0, 0);        // no match, level follows sample
    send_item(-32'sd1000, 2'd0, 0);     // lolo raise
    send_item(-32'sd960, 2'd3, 2);      // band match, severity not raised
    send_item(-32'sd955, 2'd2, 0);
    send_item(-32'sd600, 2'd1, 0);      // low matches at equal severity
    send_item(32'd2000, 2'd2, 0);       // hihi blocks lower levels
    send_item(32'd0, 2'd0, 0);
    send_item(VAL_MAX, 2'd0, 0);
    send_item(VAL_MIN, 2'd0, 0);
    drain();

    // limits at the ends of the range, widest band
    cfg_limits(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 31'h7FFF_FFFF, 8'hFF);
    send_item(VAL_MAX, 2'd0, 0);
    send_item(VAL_MAX - 1, 2'd0, 0);
    send_item(VAL_MIN, 2'd0, 0);
    send_item(32'd0, 2'd0, 0);
    send_item(VAL_MAX, 2'd3, 0);
    drain();

    // crossed limits: hihi catches everything
    cfg_limits(VAL_MIN, VAL_MAX, 32'd0, 32'd0, 31'd0, 8'h01);
    send_item(32'd0, 2'd0, 0);
    send_item(VAL_MIN, 2'd1, 0);
    drain();

    // receiver holds off while the sender keeps offering
    hold_req <= 1'b1;
    run_random(CFG_ORDERED, 130, 1'b1);
    run_random(CFG_ORDERED, 130, 1'b0);
    run_random(CFG_WIDE_BAND, 130, 1'b0);
    run_random(CFG_SCATTER, 130, 1'b0);
    run_random(CFG_EXTREME, 130, 1'b0);
    run_random(CFG_DISABLED, 130, 1'b0);
    run_random(CFG_NO_BAND, 130, 1'b0);
    run_random(CFG_ORDERED, 130, 1'b0);

    repeat (10) @(posedge clk);
    $display("covered %0d samples under %0d limit settings, %0d results checked",
             sb.n_items, n_configs, sb.n_results);
    $display("alarms raised %0d, matched without raise %0d, band holds %0d, clears %0d",
             sb.n_raised, sb.n_held, sb.n_band, sb.n_clear);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
